[rtl/assert_macros.svh]
// Assertion macros used by the top-level generator file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/pcg_pkg.sv]
// ----------------------------------------------------------------------------
// PCG64 package
// Types, command and register codes, constants and helper functions.
// ----------------------------------------------------------------------------
package pcg_pkg;

  localparam logic [127:0] MUL_CONST = {64'h2360ed051fc65da4, 64'h4385df649fccf645};
  localparam int ROT_SHIFT = 58;
  localparam int MAX_DRAWS = 256;
  localparam int DRAW_CNT_W = $clog2(MAX_DRAWS);
  localparam int MUL_STEPS = 10;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);

  localparam logic [2:0] CMD_NEXT64 = 3'd0;
  localparam logic [2:0] CMD_NEXT32 = 3'd1;
  localparam logic [2:0] CMD_INCL   = 3'd2;
  localparam logic [2:0] CMD_EXCL   = 3'd3;
  localparam logic [2:0] CMD_RESEED = 3'd4;

  localparam logic [2:0] REG_STATE_HIGH  = 3'd0;
  localparam logic [2:0] REG_STATE_LOW   = 3'd1;
  localparam logic [2:0] REG_STREAM_HIGH = 3'd2;
  localparam logic [2:0] REG_STREAM_LOW  = 3'd3;
  localparam logic [2:0] REG_SEED_MODE   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_DIV_THR, S_DRAW, S_MUL, S_CHECK, S_DIV_RES, S_DONE
  } state_t;

  // Word indexes of the partial products that land below bit 128.
  function automatic logic [3:0] mul_pair(input logic [MUL_CNT_W-1:0] k);
    logic [3:0] r;
    begin
      case (k)
        4'd0:    r = {2'd0, 2'd0};
        4'd1:    r = {2'd0, 2'd1};
        4'd2:    r = {2'd1, 2'd0};
        4'd3:    r = {2'd0, 2'd2};
        4'd4:    r = {2'd1, 2'd1};
        4'd5:    r = {2'd2, 2'd0};
        4'd6:    r = {2'd0, 2'd3};
        4'd7:    r = {2'd1, 2'd2};
        4'd8:    r = {2'd2, 2'd1};
        default: r = {2'd3, 2'd0};
      endcase
      return r;
    end
  endfunction

  function automatic logic [63:0] xsl_rr(input logic [127:0] s);
    logic [63:0]  x;
    logic [5:0]   rot;
    logic [127:0] xx;
    begin
      x   = s[127:64] ^ s[63:0];
      rot = s[127:ROT_SHIFT+64];
      xx  = {x, x} >> rot;
      return xx[63:0];
    end
  endfunction

  function automatic logic [63:0] fill_mask(input logic [63:0] m);
    logic [63:0] r;
    begin
      r = m;
      r = r | (r >> 1);
      r = r | (r >> 2);
      r = r | (r >> 4);
      r = r | (r >> 8);
      r = r | (r >> 16);
      r = r | (r >> 32);
      return r;
    end
  endfunction

endpackage

[rtl/pcg_req_if.sv]
// ----------------------------------------------------------------------------
// PCG64 request channel
// Valid/ready channel that carries one command item.
// ----------------------------------------------------------------------------
interface pcg_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [63:0] bound;
  logic [63:0] offset;

  modport source (output valid, command, bound, offset, input ready);
  modport sink (input valid, command, bound, offset, output ready);
endinterface

[rtl/pcg_rsp_if.sv]
// ----------------------------------------------------------------------------
// PCG64 response channel
// Valid/ready channel that carries one drawn value.
// ----------------------------------------------------------------------------
interface pcg_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] random_value;

  modport source (output valid, random_value, input ready);
  modport sink (input valid, random_value, output ready);
endinterface

[rtl/pcg_mul.sv]
// ----------------------------------------------------------------------------
// PCG64 LCG step unit
// Computes a * multiplier + inc modulo 2^128 with one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module pcg_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] a_in,
  input  logic [127:0] inc_in,
  output logic         done,
  output logic [127:0] result
);
  import pcg_pkg::*;

  logic [127:0]         a;
  logic [127:0]         acc;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 busy;
  logic [63:0]          prod;
  logic [1:0]           pshift;
  logic                 pvalid;
  logic                 plast;
  logic [3:0]           pair;
  logic [31:0]          aw;
  logic [31:0]          mw;
  logic [2:0]           wsum;

  assign pair   = mul_pair(cnt);
  assign aw     = a[{pair[3:2], 5'd0} +: 32];
  assign mw     = MUL_CONST[{pair[1:0], 5'd0} +: 32];
  assign wsum   = {1'b0, pair[3:2]} + {1'b0, pair[1:0]};
  assign result = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      pvalid <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      pvalid <= busy;
      done   <= pvalid && plast;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a   <= a_in;
      acc <= inc_in;
    end else if (pvalid) begin
      acc <= acc + ({64'd0, prod} << {pshift, 5'd0});
    end
    prod   <= 64'(aw) * 64'(mw);
    pshift <= wsum[1:0];
    plast  <= (cnt == MUL_CNT_W'(MUL_STEPS - 1));
  end
endmodule

[rtl/pcg_div.sv]
// ----------------------------------------------------------------------------
// PCG64 remainder unit
// Restoring division, one quotient bit per cycle, returns the remainder.
// ----------------------------------------------------------------------------
module pcg_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] remainder
);
  import pcg_pkg::*;

  logic [63:0] q;
  logic [63:0] d;
  logic [63:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [64:0] trial;
  logic [64:0] diff;

  assign trial     = {rem, q[63]};
  assign diff      = trial - {1'b0, d};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 6'd63);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      d   <= divisor;
      rem <= '0;
    end else if (busy) begin
      q <= {q[62:0], 1'b0};
      if (!diff[64]) begin
        rem <= diff[63:0];
      end else begin
        rem <= trial[63:0];
      end
    end
  end
endmodule

[rtl/pcg64_bounded_random_generator.sv]
// A next64 item waits on the ten passes of the shared 32x32 multiplier in the LCG step.
// A buffered next32 uses the spare half and skips the step.
// Bounded draws repeat the step per rejected draw; the exclusive bound adds two
// remainder passes when it is two or more. One item is in flight at a time.
// Reset: state 0, increment 1, spare half cleared, seed registers 0.
// ----------------------------------------------------------------------------
// PCG64 bounded random generator
// XSL-RR PCG64 with 32-bit buffering, bounded draws and reseeding.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module pcg64_bounded_random_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  pcg_req_if.sink     request,
  pcg_rsp_if.source   response
);
  import pcg_pkg::*;

  state_t state, state_next;

  logic [127:0] seed_state;
  logic [127:0] seed_stream;
  logic         seed_mode;

  logic [127:0] lcg_state, lcg_state_next;
  logic [127:0] increment, increment_next;
  logic [31:0]  spare_half, spare_half_next;
  logic         spare_valid, spare_valid_next;

  logic [2:0]            cmd, cmd_next;
  logic [63:0]           bound, bound_next;
  logic [63:0]           offset, offset_next;
  logic [63:0]           mask, mask_next;
  logic [63:0]           thr, thr_next;
  logic [63:0]           v, v_next;
  logic [DRAW_CNT_W-1:0] n, n_next;
  logic [63:0]           res, res_next;
  logic                  resp_valid, resp_valid_next;
  logic [63:0]           resp_data, resp_data_next;

  logic         mul_start;
  logic [127:0] mul_a;
  logic [127:0] mul_inc;
  logic         mul_done;
  logic [127:0] mul_result;
  logic         div_start;
  logic [63:0]  div_n;
  logic [63:0]  div_d;
  logic         div_done;
  logic [63:0]  div_rem;

  logic         use32;
  logic         last_draw;
  logic [63:0]  vm;
  logic [63:0]  word;
  logic [127:0] mix_inc;
  logic         fire;

  assign fire      = request.valid && request.ready;
  assign use32     = (cmd == CMD_NEXT32) || (cmd == CMD_INCL && bound[63:32] == 32'd0);
  assign last_draw = (n == DRAW_CNT_W'(MAX_DRAWS - 1));
  assign vm        = v & mask;
  assign word      = xsl_rr(mul_result);
  assign mix_inc   = {seed_stream[126:0], 1'b1};

  assign request.ready         = (state == S_IDLE);
  assign response.valid        = resp_valid;
  assign response.random_value = resp_data;

  pcg_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a_in   (mul_a),
    .inc_in (mul_inc),
    .done   (mul_done),
    .result (mul_result)
  );

  pcg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_n),
    .divisor   (div_d),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_state  <= '0;
      seed_stream <= '0;
      seed_mode   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STATE_HIGH:  seed_state[127:64]  <= cfg_data;
        REG_STATE_LOW:   seed_state[63:0]    <= cfg_data;
        REG_STREAM_HIGH: seed_stream[127:64] <= cfg_data;
        REG_STREAM_LOW:  seed_stream[63:0]   <= cfg_data;
        REG_SEED_MODE:   seed_mode           <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      lcg_state   <= '0;
      increment   <= 128'd1;
      spare_half  <= '0;
      spare_valid <= 1'b0;
      resp_valid  <= 1'b0;
    end else begin
      state       <= state_next;
      lcg_state   <= lcg_state_next;
      increment   <= increment_next;
      spare_half  <= spare_half_next;
      spare_valid <= spare_valid_next;
      resp_valid  <= resp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd       <= cmd_next;
    bound     <= bound_next;
    offset    <= offset_next;
    mask      <= mask_next;
    thr       <= thr_next;
    v         <= v_next;
    n         <= n_next;
    res       <= res_next;
    resp_data <= resp_data_next;
  end

  always_comb begin
    state_next       = state;
    lcg_state_next   = lcg_state;
    increment_next   = increment;
    spare_half_next  = spare_half;
    spare_valid_next = spare_valid;
    cmd_next         = cmd;
    bound_next       = bound;
    offset_next      = offset;
    mask_next        = mask;
    thr_next         = thr;
    v_next           = v;
    n_next           = n;
    res_next         = res;
    resp_valid_next  = resp_valid && !response.ready;
    resp_data_next   = resp_data;
    mul_start        = 1'b0;
    mul_a            = lcg_state;
    mul_inc          = increment;
    div_start        = 1'b0;
    div_n            = v;
    div_d            = bound;

    unique case (state)
      S_IDLE: begin
        if (fire) begin
          cmd_next    = request.command;
          bound_next  = request.bound;
          offset_next = request.offset;
          n_next      = '0;
          state_next  = S_START;
        end
      end
      S_START: begin
        mask_next = fill_mask(bound);
        res_next  = '0;
        case (cmd)
          CMD_NEXT64, CMD_NEXT32: state_next = S_DRAW;
          CMD_INCL: begin
            if (bound == 64'd0) begin
              res_next   = offset;
              state_next = S_DONE;
            end else begin
              state_next = S_DRAW;
            end
          end
          CMD_EXCL: begin
            if (bound[63:1] == 63'd0) begin
              state_next = S_DONE;
            end else begin
              div_start  = 1'b1;
              div_n      = 64'd0 - bound;
              state_next = S_DIV_THR;
            end
          end
          CMD_RESEED: begin
            spare_half_next  = '0;
            spare_valid_next = 1'b0;
            if (seed_mode) begin
              increment_next = mix_inc;
              mul_start      = 1'b1;
              mul_a          = mix_inc + seed_state;
              mul_inc        = mix_inc;
              state_next     = S_MUL;
            end else begin
              lcg_state_next = seed_state;
              increment_next = seed_stream;
              state_next     = S_DONE;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_DIV_THR: begin
        if (div_done) begin
          thr_next   = div_rem;
          state_next = S_DRAW;
        end
      end
      S_DRAW: begin
        if (use32 && spare_valid) begin
          v_next           = {32'd0, spare_half};
          spare_valid_next = 1'b0;
          state_next       = S_CHECK;
        end else begin
          mul_start  = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          lcg_state_next = mul_result;
          if (cmd == CMD_RESEED) begin
            state_next = S_DONE;
          end else begin
            if (use32) begin
              spare_half_next  = word[63:32];
              spare_valid_next = 1'b1;
              v_next           = {32'd0, word[31:0]};
            end else begin
              v_next = word;
            end
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        case (cmd)
          CMD_INCL: begin
            if (vm <= bound) begin
              res_next   = offset + vm;
              state_next = S_DONE;
            end else if (last_draw) begin
              res_next   = offset + vm + ~bound;
              state_next = S_DONE;
            end else begin
              n_next     = n + 1'b1;
              state_next = S_DRAW;
            end
          end
          CMD_EXCL: begin
            if (v >= thr || last_draw) begin
              div_start  = 1'b1;
              state_next = S_DIV_RES;
            end else begin
              n_next     = n + 1'b1;
              state_next = S_DRAW;
            end
          end
          default: begin
            res_next   = v;
            state_next = S_DONE;
          end
        endcase
      end
      S_DIV_RES: begin
        if (div_done) begin
          res_next   = div_rem;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!resp_valid || response.ready) begin
          resp_valid_next = 1'b1;
          resp_data_next  = res;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `ASSERT_NEXT(a_busy_after_accept, fire, !request.ready)
  `ASSERT_NEXT(a_done_delivers, (state == S_DONE && !resp_valid), resp_valid)
  `ASSERT_NEXT(a_reseed_clears_spare, (state == S_START && cmd == CMD_RESEED), !spare_valid)
  `ASSERT_IMPL(a_mul_start_ok, mul_start, (state == S_DRAW || state == S_START))
endmodule
